/* design/dual_stepper_half_step_sequencer_unit_macros.svh */
// Assertion macros used by the port checker of the stepper sequencer.
`ifndef DUAL_STEPPER_HALF_STEP_SEQUENCER_UNIT_MACROS_SVH
`define DUAL_STEPPER_HALF_STEP_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define DSHSS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked while reset is high.
`define DSHSS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/dshss_pkg.sv */
package dshss_pkg;

   // Default values of the top-level parameters
   localparam int SENSOR_CHECK_INTERVAL_DEF = 20;
   localparam int STEP_COUNT_BITS_DEF       = 20;
   localparam int POSITION_BITS_DEF         = 32;

   // Fixed field widths
   localparam int CMD_BITS      = 2;
   localparam int COUNT_W       = 20;
   localparam int DIR_W         = 2;
   localparam int DIST_W        = 16;
   localparam int SPEED_W       = 7;
   localparam int COIL_W        = 4;
   localparam int HALT_W        = 2;
   localparam int POS_OUT_W     = 32;
   localparam int DELAY_W       = 12;
   localparam int PHASE_W       = 3;
   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = 16;

   // Request tdata layout, lowest bit first
   localparam int REQ_COUNT_LSB = 0;
   localparam int REQ_DIRL_LSB  = REQ_COUNT_LSB + COUNT_W;
   localparam int REQ_DIRR_LSB  = REQ_DIRL_LSB + DIR_W;
   localparam int REQ_IRL_LSB   = REQ_DIRR_LSB + DIR_W;
   localparam int REQ_IRR_LSB   = REQ_IRL_LSB + 1;
   localparam int REQ_DIST_LSB  = REQ_IRR_LSB + 1;
   localparam int REQ_ESTOP_LSB = REQ_DIST_LSB + DIST_W;
   localparam int REQ_USED_W    = REQ_ESTOP_LSB + 1;
   localparam int REQ_DATA_W    = ((REQ_USED_W + 7) / 8) * 8;

   // Response tdata layout, lowest bit first
   localparam int RSP_COILL_LSB = 0;
   localparam int RSP_COILR_LSB = RSP_COILL_LSB + COIL_W;
   localparam int RSP_BUSY_LSB  = RSP_COILR_LSB + COIL_W;
   localparam int RSP_HALT_LSB  = RSP_BUSY_LSB + 1;
   localparam int RSP_POSL_LSB  = RSP_HALT_LSB + HALT_W;
   localparam int RSP_POSR_LSB  = RSP_POSL_LSB + POS_OUT_W;
   localparam int RSP_DELAY_LSB = RSP_POSR_LSB + POS_OUT_W;
   localparam int RSP_USED_W    = RSP_DELAY_LSB + DELAY_W;
   localparam int RSP_DATA_W    = ((RSP_USED_W + 7) / 8) * 8;

   // Command codes
   typedef enum logic [CMD_BITS-1:0] {
      CMD_START  = 2'd0,
      CMD_MANUAL = 2'd1,
      CMD_TICK   = 2'd2
   } cmd_type;

   // Why the last move ended
   typedef enum logic [HALT_W-1:0] {
      HALT_NONE   = 2'd0,
      HALT_SENSOR = 2'd1,
      HALT_ESTOP  = 2'd2
   } halt_type;

   // Register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPEED     = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_THRESHOLD = 1'd1;

   localparam logic [SPEED_W-1:0] SPEED_MIN   = 7'd1;
   localparam logic [SPEED_W-1:0] SPEED_MAX   = 7'd100;
   localparam logic [SPEED_W-1:0] SPEED_RESET = 7'd50;

   // Delay = 3000 - floor((s-1)*2350/99), split as 2350 = 23*99 + 73.
   // floor(y/99) for y < 32768 is (y*10592)>>20, folded into one constant.
   localparam logic [DELAY_W-1:0] DELAY_SLOW     = 12'd3000;
   localparam logic [DELAY_W-1:0] DELAY_WHOLE    = 12'd23;
   localparam int                 DELAY_FRAC_SH  = 20;
   localparam int                 DELAY_FRAC_W   = 27;
   localparam logic [DELAY_FRAC_W-1:0] DELAY_FRAC_MUL = 27'd773216;

   typedef logic signed [DIR_W-1:0] dir_type;

   // One accepted request, unpacked
   typedef struct packed {
      logic [CMD_BITS-1:0] cmd;
      logic [COUNT_W-1:0]  step_count;
      logic [DIR_W-1:0]    dir_left;
      logic [DIR_W-1:0]    dir_right;
      logic                ir_left_clear;
      logic                ir_right_clear;
      logic [DIST_W-1:0]   distance;
      logic                emergency_stop;
   } item_type;

   // Settings handed from the register block to the engine
   typedef struct packed {
      logic [DIST_W-1:0]  obstacle_threshold;
      logic [DELAY_W-1:0] step_delay_us;
   } cfg_type;

   // Half-step coil pattern for a phase
   function automatic logic [COIL_W-1:0] half_step(input logic [PHASE_W-1:0] phase);
      logic [COIL_W-1:0] pat;
      case (phase)
         3'd0:    pat = 4'b1000;
         3'd1:    pat = 4'b1100;
         3'd2:    pat = 4'b0100;
         3'd3:    pat = 4'b0110;
         3'd4:    pat = 4'b0010;
         3'd5:    pat = 4'b0011;
         3'd6:    pat = 4'b0001;
         default: pat = 4'b1001;
      endcase
      return pat;
   endfunction

   // Raw code 10 saturates to -1
   function automatic dir_type decode_dir(input logic [DIR_W-1:0] raw);
      return (raw == 2'b10) ? dir_type'(2'b11) : dir_type'(raw);
   endfunction

   function automatic logic [SPEED_W-1:0] clamp_speed(input logic [SPEED_W-1:0] s);
      logic [SPEED_W-1:0] r;
      if (s < SPEED_MIN) begin
         r = SPEED_MIN;
      end else if (s > SPEED_MAX) begin
         r = SPEED_MAX;
      end else begin
         r = s;
      end
      return r;
   endfunction

   function automatic logic [DELAY_W-1:0] step_delay(input logic [SPEED_W-1:0] s);
      logic [SPEED_W-1:0]      s1;
      logic [DELAY_W-1:0]      whole;
      logic [DELAY_FRAC_W-1:0] frac;
      s1    = s - SPEED_MIN;
      whole = DELAY_W'(s1) * DELAY_WHOLE;
      frac  = DELAY_FRAC_W'(s1) * DELAY_FRAC_MUL;
      return DELAY_SLOW - whole - DELAY_W'(frac >> DELAY_FRAC_SH);
   endfunction

endpackage

/* design/dshss_csr.sv */
module dshss_csr
   import dshss_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   output cfg_type                  cfg
);

   logic [SPEED_W-1:0] speed_ff;
   logic [DIST_W-1:0]  threshold_ff;

   // register writes, speed clamped on the way in
   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff     <= SPEED_RESET;
         threshold_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SPEED:     speed_ff     <= clamp_speed(csr_wdata[SPEED_W-1:0]);
            CSR_THRESHOLD: threshold_ff <= csr_wdata[DIST_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg.obstacle_threshold = threshold_ff;
   assign cfg.step_delay_us      = step_delay(speed_ff);

endmodule

/* design/dshss_ingress.sv */
module dshss_ingress
   import dshss_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_W-1:0]    req_tdata,
   input  logic [CMD_BITS-1:0]      req_tuser,
   input  logic                     eng_ready,
   output logic                     item_vld,
   output item_type                 item
);

   logic     vld_ff;
   item_type item_ff;

   // the slot frees when it is empty or the engine takes its transaction
   assign req_tready = !vld_ff || eng_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (req_tready) begin
         vld_ff <= req_tvalid;
      end
   end

   // unpack on acceptance
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff.cmd            <= req_tuser;
         item_ff.step_count     <= req_tdata[REQ_COUNT_LSB +: COUNT_W];
         item_ff.dir_left       <= req_tdata[REQ_DIRL_LSB +: DIR_W];
         item_ff.dir_right      <= req_tdata[REQ_DIRR_LSB +: DIR_W];
         item_ff.ir_left_clear  <= req_tdata[REQ_IRL_LSB];
         item_ff.ir_right_clear <= req_tdata[REQ_IRR_LSB];
         item_ff.distance       <= req_tdata[REQ_DIST_LSB +: DIST_W];
         item_ff.emergency_stop <= req_tdata[REQ_ESTOP_LSB];
      end
   end

   assign item_vld = vld_ff;
   assign item     = item_ff;

endmodule

/* design/dshss_engine.sv */
module dshss_engine
   import dshss_pkg::*;
#(
   parameter int SENSOR_CHECK_INTERVAL = SENSOR_CHECK_INTERVAL_DEF,
   parameter int STEP_COUNT_BITS       = STEP_COUNT_BITS_DEF,
   parameter int POSITION_BITS         = POSITION_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_vld,
   input  item_type              item,
   input  cfg_type               cfg,
   output logic                  eng_ready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int ChkBits = (SENSOR_CHECK_INTERVAL > 1) ? $clog2(SENSOR_CHECK_INTERVAL) : 1;
   localparam logic [ChkBits-1:0] ChkLast = ChkBits'(SENSOR_CHECK_INTERVAL - 1);

   // move state
   logic [PHASE_W-1:0]              lphase_ff, lphase_in;
   logic [PHASE_W-1:0]              rphase_ff, rphase_in;
   logic signed [POSITION_BITS-1:0] lpos_ff, lpos_in;
   logic signed [POSITION_BITS-1:0] rpos_ff, rpos_in;
   logic [STEP_COUNT_BITS-1:0]      done_ff, done_in;
   logic [STEP_COUNT_BITS-1:0]      total_ff, total_in;
   logic [ChkBits-1:0]              chk_ff, chk_in;
   dir_type                         mdl_ff, mdl_in;
   dir_type                         mdr_ff, mdr_in;
   logic                            moving_ff, moving_in;
   halt_type                        cause_ff, cause_in;
   logic [2*COIL_W-1:0]             coil_ff, coil_in;

   // result register
   logic                  out_vld_ff;
   logic [RSP_DATA_W-1:0] out_data_ff, out_data_in;

   logic    fire;
   logic    step_en;
   dir_type step_l, step_r;
   dir_type in_l, in_r;
   logic    sensor_hit;

   assign eng_ready = !out_vld_ff || rsp_tready;
   assign fire      = item_vld && eng_ready;

   assign in_l = decode_dir(item.dir_left);
   assign in_r = decode_dir(item.dir_right);

   // obstacle or edge on a sampling step of a straight forward move
   assign sensor_hit = (chk_ff == '0) && (mdl_ff == dir_type'(2'sd1))
                       && (mdr_ff == dir_type'(2'sd1))
                       && (!item.ir_left_clear || !item.ir_right_clear
                           || (item.distance < cfg.obstacle_threshold));

   // command decode and next state
   always_comb begin
      done_in   = done_ff;
      total_in  = total_ff;
      chk_in    = chk_ff;
      mdl_in    = mdl_ff;
      mdr_in    = mdr_ff;
      moving_in = moving_ff;
      cause_in  = cause_ff;
      coil_in   = coil_ff;
      step_en   = 1'b0;
      step_l    = in_l;
      step_r    = in_r;
      case (item.cmd)
         CMD_START: begin
            total_in  = STEP_COUNT_BITS'(item.step_count);
            done_in   = '0;
            chk_in    = '0;
            mdl_in    = in_l;
            mdr_in    = in_r;
            cause_in  = HALT_NONE;
            moving_in = (total_in != '0);
            if (total_in == '0) begin
               coil_in = '0;
            end
         end
         CMD_MANUAL: begin
            step_en = !moving_ff;
         end
         CMD_TICK: begin
            if (moving_ff) begin
               if (done_ff >= total_ff) begin
                  moving_in = 1'b0;
                  cause_in  = HALT_NONE;
                  coil_in   = '0;
               end else if (sensor_hit) begin
                  moving_in = 1'b0;
                  cause_in  = HALT_SENSOR;
                  coil_in   = '0;
               end else if (item.emergency_stop) begin
                  moving_in = 1'b0;
                  cause_in  = HALT_ESTOP;
                  coil_in   = '0;
               end else begin
                  step_en = 1'b1;
                  step_l  = mdl_ff;
                  step_r  = mdr_ff;
                  done_in = done_ff + 1'b1;
                  chk_in  = (chk_ff == ChkLast) ? '0 : chk_ff + 1'b1;
               end
            end
         end
         default: ;
      endcase
      // one half step on both motors
      lphase_in = lphase_ff;
      rphase_in = rphase_ff;
      lpos_in   = lpos_ff;
      rpos_in   = rpos_ff;
      if (step_en) begin
         lphase_in = lphase_ff + PHASE_W'(step_l);
         rphase_in = rphase_ff + PHASE_W'(step_r);
         lpos_in   = lpos_ff + POSITION_BITS'(step_l);
         rpos_in   = rpos_ff + POSITION_BITS'(step_r);
         coil_in   = {half_step(lphase_in), half_step(rphase_in)};
      end
   end

   // pack the result transaction
   always_comb begin
      out_data_in = '0;
      out_data_in[RSP_COILL_LSB +: COIL_W]    = coil_in[2*COIL_W-1:COIL_W];
      out_data_in[RSP_COILR_LSB +: COIL_W]    = coil_in[COIL_W-1:0];
      out_data_in[RSP_BUSY_LSB]               = moving_in;
      out_data_in[RSP_HALT_LSB +: HALT_W]     = cause_in;
      out_data_in[RSP_POSL_LSB +: POS_OUT_W]  = POS_OUT_W'(lpos_in);
      out_data_in[RSP_POSR_LSB +: POS_OUT_W]  = POS_OUT_W'(rpos_in);
      out_data_in[RSP_DELAY_LSB +: DELAY_W]   = cfg.step_delay_us;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lphase_ff <= '0;
         rphase_ff <= '0;
         lpos_ff   <= '0;
         rpos_ff   <= '0;
         done_ff   <= '0;
         total_ff  <= '0;
         chk_ff    <= '0;
         mdl_ff    <= '0;
         mdr_ff    <= '0;
         moving_ff <= 1'b0;
         cause_ff  <= HALT_NONE;
         coil_ff   <= '0;
      end else if (fire) begin
         lphase_ff <= lphase_in;
         rphase_ff <= rphase_in;
         lpos_ff   <= lpos_in;
         rpos_ff   <= rpos_in;
         done_ff   <= done_in;
         total_ff  <= total_in;
         chk_ff    <= chk_in;
         mdl_ff    <= mdl_in;
         mdr_ff    <= mdr_in;
         moving_ff <= moving_in;
         cause_ff  <= cause_in;
         coil_ff   <= coil_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (eng_ready) begin
         out_vld_ff <= item_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

/* design/dual_stepper_half_step_sequencer_unit.sv */
// Two-motor half-step sequencer. Each request transaction carries a command
// (start a counted move, take one manual step, or one step-period tick) and
// returns exactly one response with both coil patterns, the busy flag, the
// reason the last move ended, both wrapping positions and the step delay in
// microseconds for the current speed setting. One transaction is taken per
// clock while the response side is not stalling; its response passes through
// the input register and then the result register before it is on rsp_*,
// and back-pressure on the response side reaches req_tready in the same cycle.
// Registers are written through csr_* and take effect at once: index 0 is speed
// in percent (clamped to 1..100), index 1 is the obstacle distance threshold
// (0 disables it).
module dual_stepper_half_step_sequencer_unit
   import dshss_pkg::*;
#(
   parameter int SENSOR_CHECK_INTERVAL = SENSOR_CHECK_INTERVAL_DEF,
   parameter int STEP_COUNT_BITS       = STEP_COUNT_BITS_DEF,
   parameter int POSITION_BITS         = POSITION_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // step_count, dir_left, dir_right, ir_left_clear, ir_right_clear,
   // distance, emergency_stop, zero fill
   input  logic [REQ_DATA_W-1:0]    req_tdata,
   // cmd
   input  logic [CMD_BITS-1:0]      req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // coil_left, coil_right, busy_res, halt_reason, pos_left, pos_right,
   // step_delay_us, zero fill
   output logic [RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   cfg_type  cfg;
   item_type item;
   logic     item_vld;
   logic     eng_ready;

   dshss_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dshss_ingress u_ingress (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .eng_ready  (eng_ready),
      .item_vld   (item_vld),
      .item       (item)
   );

   dshss_engine #(
      .SENSOR_CHECK_INTERVAL (SENSOR_CHECK_INTERVAL),
      .STEP_COUNT_BITS       (STEP_COUNT_BITS),
      .POSITION_BITS         (POSITION_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .item_vld   (item_vld),
      .item       (item),
      .cfg        (cfg),
      .eng_ready  (eng_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

/* design/dshss_port_checker.sv */
`include "dual_stepper_half_step_sequencer_unit_macros.svh"

module dshss_port_checker
   import dshss_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic [COIL_W-1:0]  coil_l;
   logic [COIL_W-1:0]  coil_r;
   logic               busy;
   logic [HALT_W-1:0]  halt;
   logic [DELAY_W-1:0] delay;

   assign coil_l = rsp_tdata[RSP_COILL_LSB +: COIL_W];
   assign coil_r = rsp_tdata[RSP_COILR_LSB +: COIL_W];
   assign busy   = rsp_tdata[RSP_BUSY_LSB];
   assign halt   = rsp_tdata[RSP_HALT_LSB +: HALT_W];
   assign delay  = rsp_tdata[RSP_DELAY_LSB +: DELAY_W];

   // a stalled response transaction holds
   `DSHSS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "response changed while stalled")

   // a halted move is never still busy
   `DSHSS_ASSERT_NOW(a_halt_idle, clock, reset, rsp_tvalid && (halt != HALT_NONE), !busy, "halt reason set while busy")

   // coils show off or a half-step pattern only
   `DSHSS_ASSERT_NOW(a_coil_pat, clock, reset, rsp_tvalid, ($countones(coil_l) <= 2) && (coil_l != 4'b1010) && (coil_l != 4'b0101) && ($countones(coil_r) <= 2) && (coil_r != 4'b1010) && (coil_r != 4'b0101), "illegal coil pattern")

   // delay stays within the speed map
   `DSHSS_ASSERT_NOW(a_delay_rng, clock, reset, rsp_tvalid, (delay >= 12'd650) && (delay <= 12'd3000), "step delay out of range")

endmodule

bind dual_stepper_half_step_sequencer_unit dshss_port_checker u_port_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* bench/tb_dual_stepper_half_step_sequencer_unit.sv */
module tb_dual_stepper_half_step_sequencer_unit;
   import dshss_pkg::*;

   // Command code with no defined action
   localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
   // Raw direction codes; the code 10 saturates to back
   localparam logic [DIR_W-1:0] DIR_HOLD = 2'b00;
   localparam logic [DIR_W-1:0] DIR_FWD  = 2'b01;
   localparam logic [DIR_W-1:0] DIR_SAT  = 2'b10;
   localparam logic [DIR_W-1:0] DIR_BACK = 2'b11;
   localparam int SLOW_US     = 3000;
   localparam int FAST_US     = 650;
   localparam int SPEED_SPAN  = 99;
   localparam int IDLE_PCT    = 12;
   localparam int PHASE_ITEMS = 75;
   localparam int NUM_PHASES  = 5;
   localparam int CYCLE_LIMIT = 200000;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   // step_count, dir_left, dir_right, ir_left_clear, ir_right_clear,
   // distance, emergency_stop, zero fill
   logic [REQ_DATA_W-1:0]    req_tdata = '0;
   // cmd
   logic [CMD_BITS-1:0]      req_tuser = CMD_UNUSED;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   // coil_left, coil_right, busy_res, halt_reason, pos_left, pos_right,
   // step_delay_us, zero fill
   logic [RSP_DATA_W-1:0]    rsp_tdata;
   logic                     csr_wr_en = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = CSR_SPEED;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   bit no_idle = 1'b0;
   int cycles = 0;

   // Predicts the sequencer state and holds the responses still to come
   class stepper_scoreboard;
      typedef struct packed {
         logic [COIL_W-1:0]    coil_l;
         logic [COIL_W-1:0]    coil_r;
         logic                 busy;
         logic [HALT_W-1:0]    halt;
         logic [POS_OUT_W-1:0] pos_l;
         logic [POS_OUT_W-1:0] pos_r;
         logic [DELAY_W-1:0]   delay;
      } rsp_fields_type;

      logic [COIL_W-1:0] pattern_table [8] = '{4'b1000, 4'b1100, 4'b0100, 4'b0110,
                                               4'b0010, 4'b0011, 4'b0001, 4'b1001};
      logic [SPEED_W-1:0]   speed = SPEED_RESET;
      logic [DIST_W-1:0]    threshold = '0;
      logic [PHASE_W-1:0]   ph_l = '0, ph_r = '0;
      logic [POS_OUT_W-1:0] pos_l = '0, pos_r = '0;
      logic [COUNT_W-1:0]   done = '0, total = '0;
      int                   move_l = 0, move_r = 0;
      bit                   moving = 1'b0;
      halt_type             cause = HALT_NONE;
      logic [7:0]           coils = '0;
      rsp_fields_type       pending_rsp [$];
      int checked = 0, mismatches = 0;
      int completions = 0, sensor_halts = 0, estop_halts = 0;

      function int dir_of(logic [DIR_W-1:0] raw);
         case (raw)
            DIR_FWD:  return 1;
            DIR_HOLD: return 0;
            default:  return -1;
         endcase
      endfunction

      function void advance(int dl, int dr);
         ph_l  = ph_l + PHASE_W'(dl);
         ph_r  = ph_r + PHASE_W'(dr);
         coils = {pattern_table[ph_l], pattern_table[ph_r]};
         pos_l = pos_l + POS_OUT_W'(dl);
         pos_r = pos_r + POS_OUT_W'(dr);
      endfunction

      function void stop_move(halt_type why);
         moving = 1'b0;
         cause  = why;
         coils  = '0;
      endfunction

      function void write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] val);
         logic [SPEED_W-1:0] s;
         s = val[SPEED_W-1:0];
         if (idx == CSR_SPEED) begin
            speed = (s < SPEED_MIN) ? SPEED_MIN : (s > SPEED_MAX) ? SPEED_MAX : s;
         end else begin
            threshold = val;
         end
      endfunction

      // Accepted request transaction: update state, queue the response
      function void note_item(item_type it);
         rsp_fields_type r;
         case (it.cmd)
            CMD_START: begin
               total  = it.step_count;
               done   = '0;
               move_l = dir_of(it.dir_left);
               move_r = dir_of(it.dir_right);
               cause  = HALT_NONE;
               moving = (total != 0);
               if (!moving) coils = '0;
            end
            CMD_MANUAL: begin
               if (!moving) advance(dir_of(it.dir_left), dir_of(it.dir_right));
            end
            CMD_TICK: begin
               if (moving) begin
                  if (done >= total) begin
                     stop_move(HALT_NONE);
                     completions++;
                  end else if ((done % SENSOR_CHECK_INTERVAL_DEF) == 0 &&
                               move_l > 0 && move_r > 0 &&
                               (!it.ir_left_clear || !it.ir_right_clear ||
                                it.distance < threshold)) begin
                     stop_move(HALT_SENSOR);
                     sensor_halts++;
                  end else if (it.emergency_stop) begin
                     stop_move(HALT_ESTOP);
                     estop_halts++;
                  end else begin
                     advance(move_l, move_r);
                     done = done + 1'b1;
                  end
               end
            end
            default: ;
         endcase
         r.coil_l = coils[7:4];
         r.coil_r = coils[3:0];
         r.busy   = moving;
         r.halt   = cause;
         r.pos_l  = pos_l;
         r.pos_r  = pos_r;
         r.delay  = DELAY_W'(SLOW_US - ((int'(speed) - 1) * (SLOW_US - FAST_US)) / SPEED_SPAN);
         pending_rsp.push_back(r);
      endfunction

      // Accepted response transaction: compare with the oldest prediction
      function void check_result(logic [RSP_DATA_W-1:0] d);
         rsp_fields_type want, got;
         got.coil_l = d[RSP_COILL_LSB +: COIL_W];
         got.coil_r = d[RSP_COILR_LSB +: COIL_W];
         got.busy   = d[RSP_BUSY_LSB];
         got.halt   = d[RSP_HALT_LSB +: HALT_W];
         got.pos_l  = d[RSP_POSL_LSB +: POS_OUT_W];
         got.pos_r  = d[RSP_POSR_LSB +: POS_OUT_W];
         got.delay  = d[RSP_DELAY_LSB +: DELAY_W];
         checked++;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response transaction: %h", d);
            return;
         end
         want = pending_rsp.pop_front();
         if (got.coil_l !== want.coil_l || got.coil_r !== want.coil_r ||
             got.busy !== want.busy || got.halt !== want.halt ||
             got.pos_l !== want.pos_l || got.pos_r !== want.pos_r ||
             got.delay !== want.delay) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("mismatch #%0d: exp coils %h/%h busy %b halt %0d pos %0d/%0d delay %0d",
                        checked, want.coil_l, want.coil_r, want.busy, want.halt,
                        $signed(want.pos_l), $signed(want.pos_r), want.delay);
               $display("           got coils %h/%h busy %b halt %0d pos %0d/%0d delay %0d",
                        got.coil_l, got.coil_r, got.busy, got.halt,
                        $signed(got.pos_l), $signed(got.pos_r), got.delay);
            end
         end
      endfunction
   endclass

   stepper_scoreboard sb = new();

   dual_stepper_half_step_sequencer_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Response side back-pressure
   always @(negedge clock) begin
      rsp_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   function automatic item_type unpack_req(logic [REQ_DATA_W-1:0] d, logic [CMD_BITS-1:0] u);
      item_type it;
      it.cmd            = u;
      it.step_count     = d[REQ_COUNT_LSB +: COUNT_W];
      it.dir_left       = d[REQ_DIRL_LSB +: DIR_W];
      it.dir_right      = d[REQ_DIRR_LSB +: DIR_W];
      it.ir_left_clear  = d[REQ_IRL_LSB];
      it.ir_right_clear = d[REQ_IRR_LSB];
      it.distance       = d[REQ_DIST_LSB +: DIST_W];
      it.emergency_stop = d[REQ_ESTOP_LSB];
      return it;
   endfunction

   function automatic logic [REQ_DATA_W-1:0] pack_req(item_type it);
      logic [REQ_DATA_W-1:0] d;
      d = '0;
      d[REQ_COUNT_LSB +: COUNT_W] = it.step_count;
      d[REQ_DIRL_LSB +: DIR_W]    = it.dir_left;
      d[REQ_DIRR_LSB +: DIR_W]    = it.dir_right;
      d[REQ_IRL_LSB]              = it.ir_left_clear;
      d[REQ_IRR_LSB]              = it.ir_right_clear;
      d[REQ_DIST_LSB +: DIST_W]   = it.distance;
      d[REQ_ESTOP_LSB]            = it.emergency_stop;
      return d;
   endfunction

   // Monitor: register writes, request and response transactions
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_wr_en) sb.write_reg(csr_index, csr_wdata);
         if (req_tvalid && req_tready) sb.note_item(unpack_req(req_tdata, req_tuser));
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
      end
   end

   // Random content everywhere; callers fix the fields that matter
   function automatic item_type rand_item(logic [CMD_BITS-1:0] c);
      item_type it;
      it.cmd            = c;
      it.step_count     = COUNT_W'($urandom);
      it.dir_left       = DIR_W'($urandom);
      it.dir_right      = DIR_W'($urandom);
      it.ir_left_clear  = 1'($urandom);
      it.ir_right_clear = 1'($urandom);
      it.distance       = DIST_W'($urandom);
      it.emergency_stop = 1'($urandom);
      return it;
   endfunction

   function automatic item_type start_item(logic [COUNT_W-1:0] n, logic [DIR_W-1:0] dl,
                                           logic [DIR_W-1:0] dr);
      item_type it;
      it            = rand_item(CMD_START);
      it.step_count = n;
      it.dir_left   = dl;
      it.dir_right  = dr;
      return it;
   endfunction

   function automatic item_type tick_item(logic irl, logic irr, logic [DIST_W-1:0] gap,
                                          logic estop);
      item_type it;
      it                = rand_item(CMD_TICK);
      it.ir_left_clear  = irl;
      it.ir_right_clear = irr;
      it.distance       = gap;
      it.emergency_stop = estop;
      return it;
   endfunction

   function automatic item_type manual_item(logic [DIR_W-1:0] dl, logic [DIR_W-1:0] dr);
      item_type it;
      it           = rand_item(CMD_MANUAL);
      it.dir_left  = dl;
      it.dir_right = dr;
      return it;
   endfunction

   // Send one request transaction; called and returns at a falling edge
   task automatic send_req(input item_type it);
      if (!no_idle) begin
         while ($urandom_range(0, 99) < IDLE_PCT) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.cmd;
      req_tdata  <= pack_req(it);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Wait for every predicted response, then let the pipeline empty
   task automatic drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (sb.pending_rsp.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // One random counted move with random content, mostly run to its end
   task automatic random_move(inout int items);
      logic [COUNT_W-1:0] n;
      logic [DIR_W-1:0]   dl, dr;
      logic [DIST_W-1:0]  gap;
      int                 ticks;
      n = ($urandom_range(0, 99) < 5) ? COUNT_W'($urandom) : COUNT_W'($urandom_range(1, 60));
      if ($urandom_range(0, 1) == 1) begin
         dl = DIR_FWD;
         dr = DIR_FWD;
      end else begin
         dl = DIR_W'($urandom);
         dr = DIR_W'($urandom);
      end
      send_req(start_item(n, dl, dr));
      items++;
      ticks = 0;
      while (sb.moving && ticks < 70) begin
         gap = ($urandom_range(0, 99) < 30) ? DIST_W'($urandom_range(0, 4000)) :
                                               DIST_W'($urandom);
         if ($urandom_range(0, 99) < 4) begin
            send_req(manual_item(DIR_W'($urandom), DIR_W'($urandom)));
         end else begin
            send_req(tick_item($urandom_range(0, 99) >= 3, $urandom_range(0, 99) >= 3,
                               gap, $urandom_range(0, 99) < 2));
         end
         items++;
         ticks++;
      end
   endtask

   logic [CSR_DATA_BITS-1:0] speed_set [NUM_PHASES];
   logic [CSR_DATA_BITS-1:0] thresh_set [NUM_PHASES];

   initial begin
      int items;
      int pick;
      speed_set  = '{16'd100, 16'd127, 16'hFF80, CSR_DATA_BITS'($urandom),
                     CSR_DATA_BITS'($urandom_range(0, 127))};
      thresh_set = '{16'hFFFF, 16'd0, 16'd2000, CSR_DATA_BITS'($urandom),
                     CSR_DATA_BITS'($urandom_range(0, 3000))};
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: speed below range, small threshold
      write_csr(CSR_SPEED, 16'd0);
      write_csr(CSR_THRESHOLD, 16'd100);
      send_req(tick_item(1'b1, 1'b1, 16'hFFFF, 1'b0));       // tick while idle
      send_req(rand_item(CMD_UNUSED));                       // undefined command
      send_req(manual_item(DIR_FWD, DIR_SAT));               // saturating direction
      send_req(manual_item(DIR_BACK, DIR_HOLD));
      send_req(start_item('0, DIR_FWD, DIR_FWD));            // zero count start
      // edge sensor halt at the first check
      send_req(start_item(20'd3, DIR_FWD, DIR_FWD));
      send_req(tick_item(1'b0, 1'b1, 16'hFFFF, 1'b0));
      // emergency halt
      send_req(start_item(20'd2, DIR_FWD, DIR_FWD));
      send_req(tick_item(1'b1, 1'b1, 16'hFFFF, 1'b1));
      // edge and emergency together: sensor wins
      send_req(start_item(20'd2, DIR_FWD, DIR_FWD));
      send_req(tick_item(1'b1, 1'b0, 16'hFFFF, 1'b1));
      // obstacle closer than the threshold
      send_req(start_item(20'd2, DIR_FWD, DIR_FWD));
      send_req(tick_item(1'b1, 1'b1, 16'h0000, 1'b0));
      // backward move to completion, manual ignored while moving
      send_req(start_item(20'd2, DIR_BACK, DIR_SAT));
      send_req(tick_item(1'b1, 1'b1, 16'h0000, 1'b0));
      send_req(manual_item(DIR_FWD, DIR_FWD));
      send_req(tick_item(1'b1, 1'b1, 16'h0000, 1'b0));
      send_req(tick_item(1'b1, 1'b1, 16'h0000, 1'b0));
      // largest count, then replaced by a new move
      send_req(start_item(20'hFFFFF, DIR_HOLD, DIR_FWD));
      send_req(tick_item(1'b1, 1'b1, 16'hFFFF, 1'b0));
      send_req(start_item(20'd1, DIR_FWD, DIR_BACK));
      send_req(tick_item(1'b1, 1'b1, 16'hFFFF, 1'b0));
      send_req(tick_item(1'b1, 1'b1, 16'hFFFF, 1'b0));
      drain();

      // Random phases, one register setting each
      for (int p = 0; p < NUM_PHASES; p++) begin
         write_csr(CSR_SPEED, speed_set[p]);
         write_csr(CSR_THRESHOLD, thresh_set[p]);
         no_idle = (p == 1);
         items = 0;
         while (items < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
               random_move(items);
            end else if (pick < 92) begin
               send_req(manual_item(DIR_W'($urandom), DIR_W'($urandom)));
               items++;
            end else begin
               send_req(rand_item(CMD_BITS'($urandom)));
               items++;
            end
         end
         drain();
         no_idle = 1'b0;
      end

      repeat (8) @(negedge clock);
      $display("checked %0d responses across %0d register settings",
               sb.checked, NUM_PHASES + 1);
      $display("moves completed %0d, sensor halts %0d, emergency halts %0d, mismatches %0d",
               sb.completions, sb.sensor_halts, sb.estop_halts, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending_rsp.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
